/* hdl/dmxrx_pkg.sv */
// Shared constants, codes and control types for the DMX512 frame receiver.
package dmxrx_pkg;

  // Default frame length in channels.
  localparam int CHANNELS_DEF = 512;

  // Width of channel counts: holds 0 to 1023, enough for 512.
  localparam int CNT_W = 10;

  // Counter width of the frame statistics.
  localparam int CTR_W = 32;

  // Reset value of the minimum channel count register.
  localparam logic [CNT_W-1:0] MIN_FRAME_RST = 10'd16;

  // Non-empty frames shorter than this are always noise.
  localparam logic [CNT_W-1:0] MIN_GOOD_CHANNELS = 10'd16;

  // Start code and noise byte patterns.
  localparam logic [7:0] OPEN_CODE = 8'h00;
  localparam logic [7:0] NOISE_A   = 8'h55;
  localparam logic [7:0] NOISE_B   = 8'hAA;
  localparam logic [7:0] NOISE_C   = 8'hDD;

  // Noise ratio limit as an integer fraction: noise/channels > 99/100.
  localparam int RATIO_W     = 17;
  localparam int NOISE_SCALE = 100;
  localparam int NOISE_LIMIT = 99;

  // Item modes.
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_GAP   = 2'd1;
  localparam logic [1:0] MODE_BREAK = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Frame event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_NOISE  = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;
    logic exec;
    logic check;
    logic copy;
    logic read;
    logic finish;
  } dmxrx_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic commit_req;
    logic read_req;
    logic start_copy;
    logic copy_done;
    logic out_free;
  } dmxrx_status_t;

endpackage

/* hdl/dmxrx_ctrl.sv */
// Controller state machine for the DMX512 frame receiver.
module dmxrx_ctrl import dmxrx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dmxrx_status_t status,
  output dmxrx_cmd_t    cmd,
  output logic          busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.commit_req) begin
          state_next = S_CHECK;
        end else if (status.read_req) begin
          state_next = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = status.start_copy ? S_COPY : S_FINISH;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_done) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* hdl/dmxrx_datapath.sv */
// Datapath of the DMX512 frame receiver: frame state, memories, counters, result.
module dmxrx_datapath import dmxrx_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dmxrx_cmd_t       cmd,
  output dmxrx_status_t    status,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [8:0]       read_channel,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [1:0]       frame_event,
  output logic [CNT_W-1:0] frame_channels,
  output logic [CTR_W-1:0] accepted_frames,
  output logic [CTR_W-1:0] valid_run,
  output logic [CTR_W-1:0] noise_run,
  output logic [7:0]       read_value
);

  localparam int ADDR_W = $clog2(CHANNELS);
  localparam logic [CNT_W-1:0] CH_MAX  = CNT_W'(CHANNELS);
  localparam logic [CNT_W-1:0] CH_LAST = CNT_W'(CHANNELS - 1);

  // Configuration
  logic [CNT_W-1:0] min_frame;

  // Latched item
  logic [1:0] it_mode;
  logic [7:0] it_byte;
  logic [8:0] it_rch;

  // Frame state
  logic             in_frame;
  logic             gap_seen;
  logic [CNT_W-1:0] channel_count;
  logic [CNT_W-1:0] noise_bytes;

  // Statistics
  logic [CTR_W-1:0] frame_total;
  logic [CTR_W-1:0] valid_counter;
  logic [CTR_W-1:0] noise_counter;

  // Channel store entries at or above store_fill were never written: read as zero
  logic [CNT_W-1:0] store_fill;

  // Memories
  logic [7:0] buf_mem   [CHANNELS];
  logic [7:0] store_mem [CHANNELS];
  logic [7:0] buf_rdata;
  logic [7:0] store_rdata;

  // Copy sweep
  logic [CNT_W-1:0]  cp_rd_idx;
  logic [ADDR_W-1:0] cp_wr_idx;
  logic              cp_wr_pend;

  // Pending result
  logic [1:0]       ev_r;
  logic [CNT_W-1:0] chans_r;
  logic [7:0]       rval_r;

  logic             is_noise_byte;
  logic             buf_write;
  logic             count_open;
  logic [RATIO_W-1:0] noise_scaled;
  logic [RATIO_W-1:0] chans_scaled;
  logic             frame_noisy;
  logic             rch_stored;

  assign is_noise_byte = it_byte inside {NOISE_A, NOISE_B, NOISE_C};
  assign count_open    = (channel_count < CH_MAX);
  assign buf_write     = cmd.exec && (it_mode == MODE_BYTE) && in_frame && count_open;

  assign noise_scaled = RATIO_W'(noise_bytes) * RATIO_W'(NOISE_SCALE);
  assign chans_scaled = RATIO_W'(channel_count) * RATIO_W'(NOISE_LIMIT);
  assign frame_noisy  = (channel_count < MIN_GOOD_CHANNELS) || (noise_scaled > chans_scaled);
  assign rch_stored   = ({1'b0, it_rch} < store_fill);

  always_comb begin
    status = '0;
    case (it_mode)
      MODE_BYTE:  status.commit_req = in_frame && count_open && (channel_count == CH_LAST);
      MODE_GAP,
      MODE_BREAK: status.commit_req = in_frame && (channel_count >= min_frame);
      MODE_READ:  status.read_req   = 1'b1;
      default:    status.commit_req = 1'b0;
    endcase
    status.start_copy = (channel_count != '0) && !frame_noisy;
    status.copy_done  = !(cp_rd_idx < chans_r) && !cp_wr_pend;
    status.out_free   = !out_valid || !out_stall;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame <= MIN_FRAME_RST;
    end else if (cfg_write) begin
      min_frame <= cfg_data;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_mode <= mode;
      it_byte <= data_byte;
      it_rch  <= read_channel;
    end
  end

  // Frame state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      gap_seen      <= 1'b0;
      channel_count <= '0;
      noise_bytes   <= '0;
      frame_total   <= '0;
      valid_counter <= '0;
      noise_counter <= '0;
      store_fill    <= '0;
    end else if (cmd.exec) begin
      case (it_mode)
        MODE_BYTE: begin
          if (!in_frame) begin
            if ((it_byte == OPEN_CODE) && gap_seen) begin
              in_frame      <= 1'b1;
              channel_count <= '0;
              noise_bytes   <= '0;
              gap_seen      <= 1'b0;
            end
          end else if (count_open) begin
            channel_count <= channel_count + 1'b1;
            if (is_noise_byte) begin
              noise_bytes <= noise_bytes + 1'b1;
            end
          end
        end
        MODE_GAP: begin
          gap_seen <= 1'b1;
        end
        MODE_BREAK: begin
          gap_seen <= 1'b1;
          // drop a short frame; a committing one is cleared at the check
          if (!status.commit_req) begin
            in_frame      <= 1'b0;
            channel_count <= '0;
            noise_bytes   <= '0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.check) begin
      if (channel_count != '0) begin
        if (frame_noisy) begin
          noise_counter <= noise_counter + 1'b1;
          valid_counter <= '0;
        end else begin
          noise_counter <= '0;
          valid_counter <= valid_counter + 1'b1;
          frame_total   <= frame_total + 1'b1;
          if (channel_count > store_fill) begin
            store_fill <= channel_count;
          end
        end
      end
      in_frame      <= 1'b0;
      channel_count <= '0;
      noise_bytes   <= '0;
    end
  end

  // Pending result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ev_r    <= EV_NONE;
      chans_r <= '0;
      rval_r  <= '0;
    end else if (cmd.check) begin
      chans_r <= channel_count;
      if (channel_count == '0) begin
        ev_r <= EV_NONE;
      end else if (frame_noisy) begin
        ev_r <= EV_NOISE;
      end else begin
        ev_r <= EV_ACCEPT;
      end
    end else if (cmd.read) begin
      rval_r <= rch_stored ? store_rdata : 8'h00;
    end
  end

  // Copy sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_wr_pend <= 1'b0;
      cp_rd_idx  <= '0;
    end else if (cmd.check) begin
      cp_wr_pend <= 1'b0;
      cp_rd_idx  <= '0;
    end else if (cmd.copy) begin
      if (cp_rd_idx < chans_r) begin
        cp_rd_idx  <= cp_rd_idx + 1'b1;
        cp_wr_pend <= 1'b1;
        cp_wr_idx  <= cp_rd_idx[ADDR_W-1:0];
      end else begin
        cp_wr_pend <= 1'b0;
      end
    end
  end

  // Frame buffer memory
  always_ff @(posedge clk) begin
    if (buf_write) begin
      buf_mem[channel_count[ADDR_W-1:0]] <= it_byte;
    end
    buf_rdata <= buf_mem[cp_rd_idx[ADDR_W-1:0]];
  end

  // Channel store memory
  always_ff @(posedge clk) begin
    if (cmd.copy && cp_wr_pend) begin
      store_mem[cp_wr_idx] <= buf_rdata;
    end
    store_rdata <= store_mem[it_rch[ADDR_W-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      frame_event     <= ev_r;
      frame_channels  <= chans_r;
      accepted_frames <= frame_total;
      valid_run       <= valid_counter;
      noise_run       <= noise_counter;
      read_value      <= rval_r;
    end
  end

endmodule

/* hdl/dmx512_frame_receiver.sv */
// Top level of the DMX512 frame receiver: controller, datapath and checks.
//
// Receives one event word at a time (a serial byte, an idle gap, a break or a
// channel read) and answers each with exactly one result word. A 0x00 start
// code after a gap opens a frame; following bytes fill a frame buffer until
// 512 channels, or until a gap or break arrives with at least
// min_frame_channels stored. A committed non-empty frame shorter than 16
// channels, or with more than 99 percent of its bytes equal to 0x55, 0xAA or
// 0xDD, counts as noise; otherwise it is copied into the channel store and
// the counters advance. The copy runs from the frame buffer to the channel
// store, which moves one entry per cycle through the single write port of
// the store. The result sits in an output register, so the next word is
// taken while the previous result still waits; only the write of a new
// result waits for that register to drain. The channel store needs no
// clearing pass after reset: a fill mark records the longest frame ever
// stored, and channels at or beyond it read as zero. Write
// min_frame_channels only while the block is idle.
module dmx512_frame_receiver import dmxrx_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  // Input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [8:0]       read_channel,
  // Output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       frame_event,
  output logic [CNT_W-1:0] frame_channels,
  output logic [CTR_W-1:0] accepted_frames,
  output logic [CTR_W-1:0] valid_run,
  output logic [CTR_W-1:0] noise_run,
  output logic [7:0]       read_value
);

  dmxrx_cmd_t    cmd;
  dmxrx_status_t status;
  logic          busy;

  // Take a word only while the controller waits for one
  assign in_stall = busy;

  dmxrx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  dmxrx_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .data_byte       (data_byte),
    .read_channel    (read_channel),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .frame_event     (frame_event),
    .frame_channels  (frame_channels),
    .accepted_frames (accepted_frames),
    .valid_run       (valid_run),
    .noise_run       (noise_run),
    .read_value      (read_value)
  );

  // An accepted frame always holds at least the minimum good length
  a_accept_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_event == EV_ACCEPT)) |-> (frame_channels >= MIN_GOOD_CHANNELS))
    else $error("accepted frame shorter than minimum");

  // No event means no frame channels reported
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_event == EV_NONE)) |-> (frame_channels == '0))
    else $error("channels reported without a frame event");

  // A noise frame resets the valid run
  a_noise_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_event == EV_NOISE)) |-> (valid_run == '0))
    else $error("valid run not cleared by noise frame");

  // An accepted frame resets the noise run
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_event == EV_ACCEPT)) |-> (noise_run == '0))
    else $error("noise run not cleared by accepted frame");

endmodule
